// ===== hdl/bpwm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpwm_pkg
// Shared types, widths and helpers for the block peak window meter.
// ----------------------------------------------------------------------------
package bpwm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PEAK_W     = 15;
  localparam int WINDOW_DEF = 3;

  localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
  } in_t;

  typedef struct packed {
    logic [PEAK_W-1:0] block_peak;
    logic [PEAK_W-1:0] window_peak;
  } out_t;

  // data handed from one history cell to the next
  typedef struct packed {
    logic [PEAK_W-1:0] peak;
    logic              valid;
    logic [PEAK_W-1:0] run_max;
  } link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EMIT
  } state_t;

  function automatic logic [PEAK_W-1:0] magnitude(input logic signed [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] neg;
    neg = ~s + 1'b1;
    if (!s[SAMPLE_W-1]) begin
      return s[PEAK_W-1:0];
    end else if (neg[SAMPLE_W-1]) begin
      // most negative code saturates
      return PEAK_MAX;
    end else begin
      return neg[PEAK_W-1:0];
    end
  endfunction

  function automatic logic [PEAK_W-1:0] peak_max(input logic [PEAK_W-1:0] a,
                                                 input logic [PEAK_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bpwm_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpwm_cell
// One history slot: holds a block peak with its valid bit, shifts it on to
// the next cell, and folds its peak into the running maximum of the chain.
// ----------------------------------------------------------------------------
module bpwm_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire logic          clear,
  input  wire bpwm_pkg::link_t link_in,
  output bpwm_pkg::link_t    link_out
);
  import bpwm_pkg::*;

  logic [PEAK_W-1:0] peak_r;
  logic              valid_r;
  logic [PEAK_W-1:0] max_r;
  logic [PEAK_W-1:0] own_val;

  assign own_val = valid_r ? peak_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clear) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= link_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      peak_r <= link_in.peak;
    end
    max_r <= peak_max(link_in.run_max, own_val);
  end

  assign link_out.peak    = peak_r;
  assign link_out.valid   = valid_r;
  assign link_out.run_max = max_r;

endmodule
`default_nettype wire

// ===== hdl/block_peak_window_meter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// block_peak_window_meter_core
// Windowed audio peak meter built on a shift chain of history cells.
// ----------------------------------------------------------------------------
// Samples and clear requests are taken only while idle. A request that ends
// a block shifts its block peak into a chain of WINDOW cells; the window
// maximum then ripples through the chain one cell per cycle while the core
// counts down in the sweep state. In the emit state the result is loaded
// into the output register and the core returns to idle for the next request;
// the emit state waits while the output register holds an untaken result.
module block_peak_window_meter_core #(
  parameter int WINDOW = bpwm_pkg::WINDOW_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bpwm_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bpwm_pkg::out_t     out_data
);
  import bpwm_pkg::*;

  localparam int CNT_W = $clog2(WINDOW + 1);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [PEAK_W-1:0] running_r;
  logic [PEAK_W-1:0] block_peak_r;
  logic              out_valid_r;
  out_t              out_data_r;

  logic              accept;
  logic              acc_clear;
  logic              acc_end;
  logic              load_out;
  logic [PEAK_W-1:0] peak_now;
  logic [WINDOW-1:0] valid_vec;

  link_t links [0:WINDOW];

  assign accept    = in_valid && in_ready;
  assign acc_clear = accept && (in_data.command == CMD_CLEAR);
  assign acc_end   = accept && (in_data.command == CMD_SAMPLE) && in_data.block_end;
  assign peak_now  = peak_max(running_r, magnitude(in_data.sample));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_end) state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (cnt_r == CNT_W'(1)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the control
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_SWEEP: in_ready = 1'b0;
      ST_EMIT:  load_out = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      running_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc_end) begin
        cnt_r <= CNT_W'(WINDOW);
      end else if (state_r == ST_SWEEP) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (acc_clear || acc_end) begin
        running_r <= '0;
      end else if (accept) begin
        running_r <= peak_now;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_end) begin
      block_peak_r <= peak_now;
    end
    if (load_out) begin
      out_data_r.block_peak  <= block_peak_r;
      out_data_r.window_peak <= links[WINDOW].run_max;
    end
  end

  // head of the chain: new block peak enters, running maximum starts at zero
  assign links[0].peak    = peak_now;
  assign links[0].valid   = 1'b1;
  assign links[0].run_max = '0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    bpwm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (acc_end),
      .clear    (acc_clear),
      .link_in  (links[i]),
      .link_out (links[i+1])
    );
    assign valid_vec[i] = links[i+1].valid;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_end_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    acc_end |=> (state_r == ST_SWEEP))
    else $error("block end did not start the sweep");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("request taken while the chain is busy");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    acc_clear |=> (valid_vec == '0))
    else $error("clear left valid history entries");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec & (valid_vec + 1'b1)) == '0))
    else $error("history valid bits are not a contiguous prefix");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT))
    else $error("result appeared outside the emit state");
`endif

endmodule
`default_nettype wire
